// File: src/mgrs_grid_reference_to_utm_macros.svh
// Assertion macros shared by the checker of the grid reference decoder.
`ifndef MGRS_GRID_REFERENCE_TO_UTM_MACROS_SVH
`define MGRS_GRID_REFERENCE_TO_UTM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MGRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MGRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mgrs_pkg.sv
// Types, constants and decode functions for the grid reference decoder.
package mgrs_pkg;

    localparam logic [23:0] SQUARE_M   = 24'd100000;
    localparam logic [23:0] CYCLE_M    = 24'd2000000;
    localparam logic [21:0] EAST_LIMIT = 22'd1000000;
    localparam logic [23:0] NORTH_MAX  = 24'd10000000;
    localparam logic [5:0]  ZONE_MAX   = 6'd60;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_Z = 8'h5A;

    localparam logic [4:0] COL_LAST = 5'd23;
    localparam logic [4:0] ROW_LAST = 5'd19;
    localparam logic [4:0] ORG_A    = 5'd0;
    localparam logic [4:0] ORG_F    = 5'd5;
    localparam logic [4:0] ORG_J    = 5'd8;
    localparam logic [4:0] ORG_S    = 5'd16;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZONE   = 3'd1,
        ST_BAND   = 3'd2,
        ST_SQUARE = 3'd3,
        ST_RANGE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_ROW,
        S_BAND,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [4:0]  cpos;
        logic [4:0]  co;
        logic [4:0]  rpos;
        logic [4:0]  ro;
        logic [23:0] minn;
    } t_decode;

    typedef struct packed {
        logic       bad;
        logic [4:0] idx;
    } t_letter;

    function automatic t_letter letter_pos(input logic [7:0] ch, input logic [7:0] last);
        t_letter    r;
        logic [7:0] d;
        d = ch - CH_A;
        if (ch > CH_I) begin
            d = d - 8'd1;
        end
        if (ch > CH_O) begin
            d = d - 8'd1;
        end
        r.bad = (ch < CH_A) || (ch > last) || (ch == CH_I) || (ch == CH_O);
        r.idx = d[4:0];
        return r;
    endfunction

    function automatic logic [1:0] mod3(input logic [5:0] z);
        logic [3:0] s;
        logic [1:0] m;
        s = {2'b00, z[1:0]} + {2'b00, z[3:2]} + {2'b00, z[5:4]};
        case (s) inside
            4'd0, 4'd3, 4'd6, 4'd9: m = 2'd0;
            4'd1, 4'd4, 4'd7:       m = 2'd1;
            4'd2, 4'd5, 4'd8:       m = 2'd2;
            default:                m = 2'd0;
        endcase
        return m;
    endfunction

    function automatic logic [23:0] band_min(input logic [4:0] bidx);
        logic [23:0] v;
        case (bidx)
            5'd0:    v = 24'd1100000;
            5'd1:    v = 24'd2000000;
            5'd2:    v = 24'd2800000;
            5'd3:    v = 24'd3700000;
            5'd4:    v = 24'd4600000;
            5'd5:    v = 24'd5500000;
            5'd6:    v = 24'd6400000;
            5'd7:    v = 24'd7300000;
            5'd8:    v = 24'd8200000;
            5'd9:    v = 24'd9100000;
            5'd10:   v = 24'd0;
            5'd11:   v = 24'd800000;
            5'd12:   v = 24'd1700000;
            5'd13:   v = 24'd2600000;
            5'd14:   v = 24'd3500000;
            5'd15:   v = 24'd4400000;
            5'd16:   v = 24'd5300000;
            5'd17:   v = 24'd6200000;
            5'd18:   v = 24'd7000000;
            5'd19:   v = 24'd7900000;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/mgrs_decode.sv
// Letter and zone decode: validity, letter positions, set origins, band minimum.
module mgrs_decode (
    input  logic [5:0]       i_zone_number,
    input  logic [7:0]       i_band_letter,
    input  logic [7:0]       i_column_letter,
    input  logic [7:0]       i_row_letter,
    output mgrs_pkg::t_decode o_dec
);
    import mgrs_pkg::*;

    t_letter    bl;
    t_letter    cl;
    t_letter    rl;
    logic [4:0] bidx;
    logic [1:0] zm3;

    always_comb begin
        bl   = letter_pos(i_band_letter, CH_X);
        cl   = letter_pos(i_column_letter, CH_Z);
        rl   = letter_pos(i_row_letter, CH_V);
        bidx = bl.idx - 5'd2;
        zm3  = mod3(i_zone_number);

        if (i_zone_number == 6'd0 || i_zone_number > ZONE_MAX) begin
            o_dec.status = ST_ZONE;
        end else if (bl.bad || i_band_letter < CH_C) begin
            o_dec.status = ST_BAND;
        end else if (cl.bad || rl.bad) begin
            o_dec.status = ST_SQUARE;
        end else begin
            o_dec.status = ST_OK;
        end

        o_dec.cpos = cl.idx;
        o_dec.rpos = rl.idx;
        o_dec.minn = band_min(bidx);
        o_dec.ro   = i_zone_number[0] ? ORG_A : ORG_F;
        case (zm3)
            2'd1:    o_dec.co = ORG_A;
            2'd2:    o_dec.co = ORG_J;
            default: o_dec.co = ORG_S;
        endcase
    end

endmodule

// File: src/mgrs_grid_reference_to_utm.sv
// Top level: MGRS grid reference to full UTM easting and northing.
//
// Usage:
//   Drive the six reference fields and raise start while busy is low; the
//   item is taken at that clock edge. busy stays high while the item is
//   worked and the next item is taken only after busy falls.
//   Each item yields exactly one result on o_utm_easting, o_utm_northing
//   and o_status, shown for one cycle with o_valid high. The receiver
//   cannot stall; it must take the result in that cycle.
// Timing:
//   A reference with a bad zone, band or square letter shows its result
//   the cycle after acceptance. A good one walks to the column letter, then
//   to the row letter, then lifts the northing to the band floor and adds
//   the in-square northing, all through one shared 24-bit add and compare
//   unit. The next item is taken in the result cycle at the earliest. On
//   error both coordinates read zero.
// Reset:
//   i_rst_n low at a clock edge returns the sequencer to idle and drops
//   any result in progress; no clearing pass is needed.
module mgrs_grid_reference_to_utm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] i_easting_in_square,
    input  logic [16:0] i_northing_in_square,
    input  logic [5:0]  i_zone_number,
    input  logic [7:0]  i_band_letter,
    input  logic [7:0]  i_column_letter,
    input  logic [7:0]  i_row_letter,
    output logic        o_valid,
    output logic [21:0] o_utm_easting,
    output logic [23:0] o_utm_northing,
    output logic [2:0]  o_status
);
    import mgrs_pkg::*;

    t_decode     dec;
    t_state      r_state, n_state;
    t_decode     r_dec, n_dec;
    logic [23:0] r_acc, n_acc;
    logic [21:0] r_east, n_east;
    logic [16:0] r_noff, n_noff;
    logic [4:0]  r_walk, n_walk;
    logic        r_valid, n_valid;
    logic [21:0] r_out_east, n_out_east;
    logic [23:0] r_out_north, n_out_north;
    t_status     r_out_status, n_out_status;

    logic [4:0]  last;
    logic [4:0]  walk_nxt;
    logic        lt;
    logic [23:0] operand;
    logic [23:0] sum;
    logic        range_bad;

    mgrs_decode u_decode (
        .i_zone_number   (i_zone_number),
        .i_band_letter   (i_band_letter),
        .i_column_letter (i_column_letter),
        .i_row_letter    (i_row_letter),
        .o_dec           (dec)
    );

    always_comb begin
        last      = (r_state == S_COL) ? COL_LAST : ROW_LAST;
        walk_nxt  = (r_walk == last) ? 5'd0 : r_walk + 5'd1;
        lt        = r_acc < r_dec.minn;
        unique case (r_state)
            S_COL, S_ROW: operand = SQUARE_M;
            S_BAND:       operand = lt ? CYCLE_M : {7'd0, r_noff};
            default:      operand = 24'd0;
        endcase
        sum       = r_acc + operand;
        range_bad = (r_east >= EAST_LIMIT) || (r_acc > NORTH_MAX);
    end

    always_comb begin
        n_state      = r_state;
        n_dec        = r_dec;
        n_acc        = r_acc;
        n_east       = r_east;
        n_noff       = r_noff;
        n_walk       = r_walk;
        n_valid      = 1'b0;
        n_out_east   = r_out_east;
        n_out_north  = r_out_north;
        n_out_status = r_out_status;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_dec  = dec;
                    n_noff = i_northing_in_square;
                    n_acc  = {7'd0, i_easting_in_square};
                    n_walk = dec.co;
                    if (dec.status != ST_OK) begin
                        n_valid      = 1'b1;
                        n_out_east   = 22'd0;
                        n_out_north  = 24'd0;
                        n_out_status = dec.status;
                    end else begin
                        n_state = S_COL;
                    end
                end
            end
            S_COL: begin
                n_acc = sum;
                if (r_walk == r_dec.cpos) begin
                    n_east  = sum[21:0];
                    n_acc   = 24'd0;
                    n_walk  = r_dec.ro;
                    n_state = S_ROW;
                end else begin
                    n_walk = walk_nxt;
                end
            end
            S_ROW: begin
                if (r_walk == r_dec.rpos) begin
                    n_state = S_BAND;
                end else begin
                    n_acc  = sum;
                    n_walk = walk_nxt;
                end
            end
            S_BAND: begin
                n_acc = sum;
                if (!lt) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (range_bad) begin
                    n_out_east   = 22'd0;
                    n_out_north  = 24'd0;
                    n_out_status = ST_RANGE;
                end else begin
                    n_out_east   = r_east;
                    n_out_north  = r_acc;
                    n_out_status = ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec        <= n_dec;
        r_acc        <= n_acc;
        r_east       <= n_east;
        r_noff       <= n_noff;
        r_walk       <= n_walk;
        r_out_east   <= n_out_east;
        r_out_north  <= n_out_north;
        r_out_status <= n_out_status;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_utm_easting  = r_out_east;
    assign o_utm_northing = r_out_north;
    assign o_status       = r_out_status;

endmodule

// File: src/mgrs_checker.sv
// Port-level checker for the grid reference decoder, bound to the top level.
`include "mgrs_grid_reference_to_utm_macros.svh"

module mgrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [21:0] o_utm_easting,
    input logic [23:0] o_utm_northing,
    input logic [2:0]  o_status
);
    import mgrs_pkg::*;

    `MGRS_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_utm_easting == 22'd0) && (o_utm_northing == 24'd0), "error result with nonzero coordinates")
    `MGRS_ASSERT_IMP(a_ok_range, i_clk, i_rst_n, o_valid && (o_status == ST_OK), (o_utm_easting >= 22'd100000) && (o_utm_easting < EAST_LIMIT) && (o_utm_northing <= NORTH_MAX), "ok result outside UTM range")
    `MGRS_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result shown while busy")
    `MGRS_ASSERT_NXT(a_accept, i_clk, i_rst_n, start && !busy, busy || o_valid, "accepted item neither worked nor answered")

endmodule

bind mgrs_grid_reference_to_utm mgrs_checker u_mgrs_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for the MGRS grid reference to UTM decoder: directed and random references.
module tb;
    import mgrs_pkg::*;

    localparam int REF_COUNT    = 650;
    localparam int SETTLE_TICKS = 64;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        logic [16:0] east_off;
        logic [16:0] north_off;
        logic [5:0]  zone;
        logic [7:0]  band;
        logic [7:0]  col;
        logic [7:0]  row;
        bit          wait_idle;
    } grid_ref_t;

    typedef struct {
        logic [21:0] east;
        logic [23:0] north;
        t_status     status;
    } utm_fix_t;

    localparam int COL_ORIGIN [6] = '{ORG_S, ORG_A, ORG_J, ORG_S, ORG_A, ORG_J};
    localparam int ROW_ORIGIN [6] = '{ORG_F, ORG_A, ORG_F, ORG_A, ORG_F, ORG_A};
    localparam int BAND_FLOOR [20] = '{
        1100000, 2000000, 2800000, 3700000, 4600000,
        5500000, 6400000, 7300000, 8200000, 9100000,
        0, 800000, 1700000, 2600000, 3500000,
        4400000, 5300000, 6200000, 7000000, 7900000
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [16:0] i_easting_in_square;
    logic [16:0] i_northing_in_square;
    logic [5:0]  i_zone_number;
    logic [7:0]  i_band_letter;
    logic [7:0]  i_column_letter;
    logic [7:0]  i_row_letter;
    logic        o_valid;
    logic [21:0] o_utm_easting;
    logic [23:0] o_utm_northing;
    logic [2:0]  o_status;

    grid_ref_t pending_refs [$];
    utm_fix_t  expected_fixes [$];
    grid_ref_t driven_ref;
    grid_ref_t next_ref;
    utm_fix_t  want;
    int        n_taken;
    int        n_decoded;
    int        n_errors;
    int        burst_left;
    int        gap_left;
    int        idle_cycles;
    bit        taken;

    mgrs_grid_reference_to_utm DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_easting_in_square  (i_easting_in_square),
        .i_northing_in_square (i_northing_in_square),
        .i_zone_number        (i_zone_number),
        .i_band_letter        (i_band_letter),
        .i_column_letter      (i_column_letter),
        .i_row_letter         (i_row_letter),
        .o_valid              (o_valid),
        .o_utm_easting        (o_utm_easting),
        .o_utm_northing       (o_utm_northing),
        .o_status             (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int alpha_index(input logic [7:0] ch, input logic [7:0] last);
        int idx;
        if (ch < CH_A || ch > last || ch == CH_I || ch == CH_O) begin
            return -1;
        end
        idx = int'(ch) - int'(CH_A);
        if (ch > CH_I) begin
            idx--;
        end
        if (ch > CH_O) begin
            idx--;
        end
        return idx;
    endfunction

    function automatic logic [7:0] alpha_at(input int idx);
        logic [7:0] ch;
        ch = CH_A + 8'(idx);
        if (ch >= CH_I) begin
            ch = ch + 8'd1;
        end
        if (ch >= CH_O) begin
            ch = ch + 8'd1;
        end
        return ch;
    endfunction

    function automatic utm_fix_t decode_grid_ref(input grid_ref_t g);
        utm_fix_t u;
        int       bpos;
        int       cpos;
        int       rpos;
        int       csteps;
        int       rsteps;
        int       n100;
        int       east;
        int       north;
        u.east   = '0;
        u.north  = '0;
        u.status = ST_OK;
        bpos = alpha_index(g.band, CH_X);
        cpos = alpha_index(g.col, CH_Z);
        rpos = alpha_index(g.row, CH_V);
        if (g.zone < 6'd1 || g.zone > ZONE_MAX) begin
            u.status = ST_ZONE;
        end else if (bpos < 2) begin
            u.status = ST_BAND;
        end else if (cpos < 0 || rpos < 0) begin
            u.status = ST_SQUARE;
        end else begin
            csteps = (cpos + 24 - COL_ORIGIN[g.zone % 6]) % 24;
            rsteps = (rpos + 20 - ROW_ORIGIN[g.zone % 6]) % 20;
            n100   = rsteps * 100000;
            while (n100 < BAND_FLOOR[bpos - 2]) begin
                n100 += 2000000;
            end
            east  = int'(g.east_off) + (csteps + 1) * 100000;
            north = int'(g.north_off) + n100;
            if (east < 100000 || east >= 1000000 || north > 10000000) begin
                u.status = ST_RANGE;
            end else begin
                u.east  = east[21:0];
                u.north = north[23:0];
            end
        end
        return u;
    endfunction

    function automatic grid_ref_t make_ref(input logic [5:0] zone, input logic [7:0] band,
                                           input logic [7:0] col, input logic [7:0] row,
                                           input logic [16:0] e, input logic [16:0] n,
                                           input bit hold);
        grid_ref_t g;
        g.zone      = zone;
        g.band      = band;
        g.col       = col;
        g.row       = row;
        g.east_off  = e;
        g.north_off = n;
        g.wait_idle = hold;
        return g;
    endfunction

    function automatic grid_ref_t random_ref();
        grid_ref_t g;
        int        pick;
        pick = $urandom_range(0, 99);
        g.zone      = 6'($urandom_range(1, 60));
        g.band      = alpha_at($urandom_range(2, 21));
        g.col       = alpha_at($urandom_range(0, 23));
        g.row       = alpha_at($urandom_range(0, 19));
        g.east_off  = 17'($urandom_range(0, 99999));
        g.north_off = 17'($urandom_range(0, 99999));
        g.wait_idle = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            g.east_off  = 17'($urandom_range(0, 131071));
            g.north_off = 17'($urandom_range(0, 131071));
        end
        if (pick < 6) begin
            g.zone = 6'($urandom_range(0, 63));
        end else if (pick < 12) begin
            g.band = 8'($urandom_range(0, 255));
        end else if (pick < 18) begin
            g.col = 8'($urandom_range(0, 255));
        end else if (pick < 21) begin
            g.row = 8'($urandom_range(0, 255));
        end else if (pick < 24) begin
            g.row = alpha_at($urandom_range(20, 23));
        end
        return g;
    endfunction

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        start                = 1'b0;
        i_easting_in_square  = '0;
        i_northing_in_square = '0;
        i_zone_number        = '0;
        i_band_letter        = '0;
        i_column_letter      = '0;
        i_row_letter         = '0;
        n_taken              = 0;
        n_decoded            = 0;
        n_errors             = 0;
        burst_left           = 0;
        gap_left             = 0;
        idle_cycles          = 0;

        pending_refs.push_back(make_ref(6'd0,  "C", "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd63, "C", "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd61, "C", "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "B", "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "I", "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "O", "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "Y", "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  8'hFF, "A", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", 8'h40, "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", "I", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", 8'h5B, "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", "A", "W", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", "A", "Z", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", "A", "O", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", "A", 8'h00, 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "C", "A", "A", 17'd0, 17'd0, 1'b1));
        pending_refs.push_back(make_ref(6'd60, "X", "Z", "V", 17'd99999, 17'd99999, 1'b0));
        pending_refs.push_back(make_ref(6'd6,  "N", "S", "F", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd2,  "N", "Z", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "M", "H", "A", 17'd0, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "M", "H", "A", 17'd0, 17'd1, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "N", "J", "A", 17'd99999, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "N", "J", "A", 17'd131071, 17'd0, 1'b0));
        pending_refs.push_back(make_ref(6'd1,  "N", "A", "A", 17'd131071, 17'd131071, 1'b0));
        for (int k = 0; k < REF_COUNT; k++) begin
            next_ref = random_ref();
            next_ref.wait_idle = (k % 100 == 99);
            pending_refs.push_back(next_ref);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_refs.size() != 0 || start || n_taken != n_decoded) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_TICKS) @(negedge i_clk);
        if (n_errors == 0 && expected_fixes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                expected_fixes.push_back(decode_grid_ref(driven_ref));
                n_taken++;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    burst_left = $urandom_range(1, 30);
                end
            end
            if (start && !taken) begin
                // hold the item until busy drops
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_refs.size() != 0 &&
                         (!pending_refs[0].wait_idle || n_taken == n_decoded)) begin
                driven_ref = pending_refs.pop_front();
                i_easting_in_square  <= driven_ref.east_off;
                i_northing_in_square <= driven_ref.north_off;
                i_zone_number        <= driven_ref.zone;
                i_band_letter        <= driven_ref.band;
                i_column_letter      <= driven_ref.col;
                i_row_letter         <= driven_ref.row;
                start                <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_decoded <= n_decoded + 1;
            if (expected_fixes.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected item east=%0d north=%0d status=%0d",
                         $time, o_utm_easting, o_utm_northing, o_status);
            end else begin
                want = expected_fixes.pop_front();
                if (o_utm_easting !== want.east) begin
                    n_errors++;
                    $display("%0t: easting expected %0d actual %0d",
                             $time, want.east, o_utm_easting);
                end
                if (o_utm_northing !== want.north) begin
                    n_errors++;
                    $display("%0t: northing expected %0d actual %0d",
                             $time, want.north, o_utm_northing);
                end
                if (o_status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
